// ===== design/lu_solve_partial_pivot_defines.svh =====
// assertion macros shared by the checker
`ifndef LU_SOLVE_PARTIAL_PIVOT_DEFINES_SVH
`define LU_SOLVE_PARTIAL_PIVOT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LSP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsp check failed");

// next-cycle implication, disabled in reset
`define LSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsp check failed");

`endif

// ===== design/lsp_pkg.sv =====
// shared types, codes and helpers of the lu solver
`timescale 1ns / 1ps
package lsp_pkg;

  localparam int VAL_W      = 32;
  localparam int REQ_W      = 2;
  localparam int IDX_PORT_W = 3;
  localparam int SIZE_W     = 4;
  localparam int STATUS_W   = 2;
  localparam int PADDR_W    = 3;

  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SOLVE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SING = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;

  localparam logic [0:0]        CFG_SIZE_IDX = 1'b0;
  localparam logic [SIZE_W-1:0] SIZE_RESET   = 4'd8;

  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fffffff;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h80000000;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PIV_A, ST_PIV_B, ST_PIV_C, ST_PIV_D, ST_RO_A, ST_RO_B,
    ST_SW_A, ST_SW_B, ST_SW_C, ST_SW_D, ST_EL_A, ST_EL_B, ST_EL_C, ST_EL_DIV,
    ST_EL_K, ST_EL_K2, ST_EL_K3, ST_EL_K4, ST_EL_WF, ST_FW_J, ST_FW_J2,
    ST_FW_J3, ST_FW_W, ST_BK_J, ST_BK_J2, ST_BK_J3, ST_BK_D, ST_BK_D2,
    ST_BK_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic zero;
  } div_stat_t;

  function automatic logic [VAL_W-1:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = VAL_MAX;
    end else if (v < -64'sd2147483648) begin
      sat32 = VAL_MIN;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

  function automatic logic sat_hit(input logic signed [63:0] v);
    sat_hit = (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

  function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
    mag32 = v[VAL_W-1] ? VAL_W'(-v) : v;
  endfunction

endpackage

// ===== design/lsp_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module lsp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lsp_mul.sv =====
// fixed-point multiplier: registered product, rounded and saturated after
`timescale 1ns / 1ps
module lsp_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               start,
  input  logic signed [lsp_pkg::VAL_W-1:0]   a,
  input  logic signed [lsp_pkg::VAL_W-1:0]   b,
  output logic signed [lsp_pkg::VAL_W-1:0]   res,
  output logic                               sat
);

  logic signed [63:0] prod;
  logic               neg;
  logic [63:0]        mag;
  logic [63:0]        rnd;

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= 64'(a) * 64'(b);
    end
  end

  // round half away from zero on the magnitude
  always_comb begin
    neg = prod[63];
    mag = neg ? 64'(-prod) : 64'(prod);
    rnd = (mag + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    sat = neg ? (rnd > 64'h80000000) : (rnd > 64'h7fffffff);
    if (sat) begin
      res = neg ? lsp_pkg::VAL_MIN : lsp_pkg::VAL_MAX;
    end else begin
      res = neg ? lsp_pkg::VAL_W'(-rnd[lsp_pkg::VAL_W-1:0]) : rnd[lsp_pkg::VAL_W-1:0];
    end
  end

endmodule

// ===== design/lsp_div.sv =====
// fixed-point divider, restoring, one quotient bit per cycle
`timescale 1ns / 1ps
module lsp_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [lsp_pkg::VAL_W-1:0] a,
  input  logic signed [lsp_pkg::VAL_W-1:0] d,
  output logic signed [lsp_pkg::VAL_W-1:0] q,
  output lsp_pkg::div_stat_t               stat
);

  localparam int NW = lsp_pkg::VAL_W + 1 + FRAC_BITS;
  localparam int CW = $clog2(NW);

  logic                        busy;
  logic                        fin;
  logic [CW-1:0]               cnt;
  logic [NW-1:0]               num;
  logic [lsp_pkg::VAL_W-1:0]   rem;
  logic [lsp_pkg::VAL_W-1:0]   md;
  logic                        neg;
  logic [lsp_pkg::VAL_W:0]     trial;
  logic                        ge;
  logic [lsp_pkg::VAL_W:0]     rem_sub;
  logic                        q_sat;

  always_comb begin
    trial   = {rem, num[NW-1]};
    ge      = trial >= {1'b0, md};
    rem_sub = trial - {1'b0, md};
    q_sat   = neg ? (num > NW'(64'h80000000)) : (num > NW'(64'h7fffffff));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      cnt  <= '0;
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        if (d == '0) begin
          // zero divisor: saturate by the sign of the numerator, zero for a zero numerator
          if (a == '0) begin
            q <= '0;
          end else begin
            q <= a[lsp_pkg::VAL_W-1] ? lsp_pkg::VAL_MIN : lsp_pkg::VAL_MAX;
          end
          stat <= '{done: 1'b1, sat: 1'b0, zero: 1'b1};
        end else begin
          busy <= 1'b1;
          cnt  <= '0;
          md   <= lsp_pkg::mag32(d);
          num  <= NW'({lsp_pkg::mag32(a), FRAC_BITS'(0)}) + NW'(lsp_pkg::mag32(d) >> 1);
          rem  <= '0;
          neg  <= a[lsp_pkg::VAL_W-1] ^ d[lsp_pkg::VAL_W-1];
        end
      end else if (busy) begin
        rem <= ge ? rem_sub[lsp_pkg::VAL_W-1:0] : trial[lsp_pkg::VAL_W-1:0];
        num <= {num[NW-2:0], ge};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        fin <= 1'b0;
        if (q_sat) begin
          q <= neg ? lsp_pkg::VAL_MIN : lsp_pkg::VAL_MAX;
        end else begin
          q <= neg ? lsp_pkg::VAL_W'(-num[lsp_pkg::VAL_W-1:0]) : num[lsp_pkg::VAL_W-1:0];
        end
        stat <= '{done: 1'b1, sat: q_sat, zero: 1'b0};
      end
    end
  end

endmodule

// ===== design/lu_solve_partial_pivot.sv =====
// lu solver with partial pivoting: sequencer around a shared multiplier and divider
//
// input channel (in_valid/in_stall): each transfer is a load of one matrix
// element (req_type 0), one right-hand-side element (req_type 1) or a solve
// (req_type 2). loads can follow back to back.
// a solve factors the stored matrix in place, then runs forward and back
// substitution and sends x[0..n-1] on the output channel (out_valid/out_stall),
// is_last marking x[n-1]; solve_status is the same on every result.
// in_stall stays high from the solve transfer until the last result is taken.
// a solve runs ram and multiplier steps plus n(n+1)/2 divisions on the
// bit-serial divider; the single ram read port and the divider set its length.
// when the receiver stalls, the current result holds and the sequencer waits.
// size_in_use sits at byte address 0 of the apb port, reset value 8.
// rst is synchronous: the sequencer returns to idle, row order to identity,
// the solution to zero; matrix and right-hand side must be loaded again.
`timescale 1ns / 1ps
module lu_solve_partial_pivot #(
  parameter int MAX_N     = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lsp_pkg::PADDR_W-1:0]           paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [lsp_pkg::REQ_W-1:0]             req_type,
  input  logic [lsp_pkg::IDX_PORT_W-1:0]        row_index,
  input  logic [lsp_pkg::IDX_PORT_W-1:0]        col_index,
  input  logic signed [lsp_pkg::VAL_W-1:0]      element_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [lsp_pkg::IDX_PORT_W-1:0]        unknown_index,
  output logic signed [lsp_pkg::VAL_W-1:0]      unknown_value,
  output logic [lsp_pkg::STATUS_W-1:0]          solve_status,
  output logic                                  is_last
);

  localparam int IDX_W = $clog2(MAX_N);
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam int AW    = $clog2(MAX_N * MAX_N);
  localparam int SUM_W = lsp_pkg::VAL_W + IDX_W + 1;

  lsp_pkg::state_t state, state_next;

  logic [lsp_pkg::SIZE_W-1:0] size_in_use;
  logic [CNT_W-1:0] n_r, n_new, i_c, j_c, k_c, m_c, o_c;
  logic             sat_flag, sing_flag;

  logic [IDX_W-1:0]                 row_order [MAX_N];
  logic signed [lsp_pkg::VAL_W-1:0] rhs_store [MAX_N];
  logic signed [lsp_pkg::VAL_W-1:0] sol       [MAX_N];

  logic [lsp_pkg::VAL_W-1:0]        best;
  logic signed [lsp_pkg::VAL_W-1:0] tmp, f, mres, diff;
  logic signed [SUM_W-1:0]          s;
  logic [IDX_W-1:0]                 ro_tmp;

  logic [IDX_W-1:0]                 sol_ridx, ro_ridx;
  logic signed [lsp_pkg::VAL_W-1:0] sol_rd, rhs_rd;
  logic [IDX_W-1:0]                 ro_rd;

  logic                             ram_we;
  logic [AW-1:0]                    ram_waddr, ram_raddr;
  logic [lsp_pkg::VAL_W-1:0]        ram_wdata, ram_rdata;

  logic                             mul_start, mul_sat;
  logic signed [lsp_pkg::VAL_W-1:0] mul_a, mul_b, mul_res;
  logic                             div_start;
  logic signed [lsp_pkg::VAL_W-1:0] div_a, div_d, div_q;
  lsp_pkg::div_stat_t               div_st;

  logic                             in_xfer, out_xfer, cfg_wr, load_ok;
  logic signed [lsp_pkg::VAL_W:0]   el_d;
  logic signed [SUM_W:0]            fw_d, bk_d;

  function automatic logic [AW-1:0] a_at(input logic [CNT_W-1:0] r,
                                         input logic [CNT_W-1:0] c);
    a_at = AW'(int'(r) * MAX_N + int'(c));
  endfunction

  lsp_ram #(.WIDTH(lsp_pkg::VAL_W), .DEPTH(MAX_N * MAX_N)) u_mat (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  lsp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .start(mul_start), .a(mul_a), .b(mul_b), .res(mul_res), .sat(mul_sat)
  );

  lsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .a(div_a), .d(div_d), .q(div_q), .stat(div_st)
  );

  always_comb begin
    in_xfer  = in_valid && !in_stall;
    out_xfer = out_valid && !out_stall;
    cfg_wr   = psel && penable && pwrite && pready;
    load_ok  = (int'(row_index) < MAX_N) && (int'(col_index) < MAX_N);
    pready   = 1'b1;
    prdata   = (paddr[2:2] == lsp_pkg::CFG_SIZE_IDX) ? 32'(size_in_use) : 32'd0;
    if (size_in_use == '0) begin
      n_new = CNT_W'(1);
    end else if (int'(size_in_use) > MAX_N) begin
      n_new = CNT_W'(MAX_N);
    end else begin
      n_new = CNT_W'(size_in_use);
    end
    sol_rd = sol[sol_ridx];
    ro_rd  = row_order[ro_ridx];
    rhs_rd = rhs_store[ro_rd];
    el_d   = (lsp_pkg::VAL_W + 1)'(tmp) - (lsp_pkg::VAL_W + 1)'(mres);
    fw_d   = (SUM_W + 1)'(rhs_rd) - (SUM_W + 1)'(s);
    bk_d   = (SUM_W + 1)'(sol_rd) - (SUM_W + 1)'(s);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      lsp_pkg::ST_IDLE: begin
        if (in_xfer && req_type == lsp_pkg::REQ_SOLVE) begin
          state_next = (n_new == CNT_W'(1)) ? lsp_pkg::ST_FW_J : lsp_pkg::ST_PIV_A;
        end
      end
      lsp_pkg::ST_PIV_A: state_next = lsp_pkg::ST_PIV_B;
      lsp_pkg::ST_PIV_B: state_next = lsp_pkg::ST_PIV_C;
      lsp_pkg::ST_PIV_C: state_next = lsp_pkg::ST_PIV_D;
      lsp_pkg::ST_PIV_D: begin
        state_next = (i_c + CNT_W'(1) == n_r) ? lsp_pkg::ST_RO_A : lsp_pkg::ST_PIV_C;
      end
      lsp_pkg::ST_RO_A: state_next = lsp_pkg::ST_RO_B;
      lsp_pkg::ST_RO_B: state_next = (m_c == j_c) ? lsp_pkg::ST_EL_A : lsp_pkg::ST_SW_A;
      lsp_pkg::ST_SW_A: state_next = lsp_pkg::ST_SW_B;
      lsp_pkg::ST_SW_B: state_next = lsp_pkg::ST_SW_C;
      lsp_pkg::ST_SW_C: state_next = lsp_pkg::ST_SW_D;
      lsp_pkg::ST_SW_D: begin
        state_next = (k_c + CNT_W'(1) == n_r) ? lsp_pkg::ST_EL_A : lsp_pkg::ST_SW_A;
      end
      lsp_pkg::ST_EL_A: state_next = lsp_pkg::ST_EL_B;
      lsp_pkg::ST_EL_B: state_next = lsp_pkg::ST_EL_C;
      lsp_pkg::ST_EL_C: state_next = lsp_pkg::ST_EL_DIV;
      lsp_pkg::ST_EL_DIV: begin
        if (div_st.done) begin
          state_next = lsp_pkg::ST_EL_K;
        end
      end
      lsp_pkg::ST_EL_K:  state_next = lsp_pkg::ST_EL_K2;
      lsp_pkg::ST_EL_K2: state_next = lsp_pkg::ST_EL_K3;
      lsp_pkg::ST_EL_K3: state_next = lsp_pkg::ST_EL_K4;
      lsp_pkg::ST_EL_K4: begin
        state_next = (k_c + CNT_W'(1) == n_r) ? lsp_pkg::ST_EL_WF : lsp_pkg::ST_EL_K;
      end
      lsp_pkg::ST_EL_WF: begin
        if (i_c + CNT_W'(1) != n_r) begin
          state_next = lsp_pkg::ST_EL_A;
        end else if (j_c + CNT_W'(2) == n_r) begin
          state_next = lsp_pkg::ST_FW_J;
        end else begin
          state_next = lsp_pkg::ST_PIV_A;
        end
      end
      lsp_pkg::ST_FW_J:  state_next = (j_c == i_c) ? lsp_pkg::ST_FW_W : lsp_pkg::ST_FW_J2;
      lsp_pkg::ST_FW_J2: state_next = lsp_pkg::ST_FW_J3;
      lsp_pkg::ST_FW_J3: state_next = lsp_pkg::ST_FW_J;
      lsp_pkg::ST_FW_W: begin
        state_next = (i_c + CNT_W'(1) == n_r) ? lsp_pkg::ST_BK_J : lsp_pkg::ST_FW_J;
      end
      lsp_pkg::ST_BK_J:  state_next = (j_c == n_r) ? lsp_pkg::ST_BK_D : lsp_pkg::ST_BK_J2;
      lsp_pkg::ST_BK_J2: state_next = lsp_pkg::ST_BK_J3;
      lsp_pkg::ST_BK_J3: state_next = lsp_pkg::ST_BK_J;
      lsp_pkg::ST_BK_D:  state_next = lsp_pkg::ST_BK_D2;
      lsp_pkg::ST_BK_D2: state_next = lsp_pkg::ST_BK_DIV;
      lsp_pkg::ST_BK_DIV: begin
        if (div_st.done) begin
          state_next = (i_c == '0) ? lsp_pkg::ST_OUT : lsp_pkg::ST_BK_J;
        end
      end
      lsp_pkg::ST_OUT: begin
        if (out_xfer && o_c + CNT_W'(1) == n_r) begin
          state_next = lsp_pkg::ST_IDLE;
        end
      end
      default: state_next = lsp_pkg::ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = a_at(i_c, k_c);
    ram_wdata = ram_rdata;
    ram_raddr = a_at(j_c, j_c);
    mul_start = 1'b0;
    mul_a     = f;
    mul_b     = ram_rdata;
    div_start = 1'b0;
    div_a     = ram_rdata;
    div_d     = tmp;
    sol_ridx  = o_c[IDX_W-1:0];
    ro_ridx   = i_c[IDX_W-1:0];
    in_stall  = (state != lsp_pkg::ST_IDLE);
    out_valid = (state == lsp_pkg::ST_OUT);
    unique case (state)
      lsp_pkg::ST_IDLE: begin
        ram_we    = in_xfer && req_type == lsp_pkg::REQ_LOAD_A && load_ok;
        ram_waddr = a_at(CNT_W'(row_index), CNT_W'(col_index));
        ram_wdata = element_value;
      end
      lsp_pkg::ST_PIV_C: ram_raddr = a_at(i_c, j_c);
      lsp_pkg::ST_RO_A:  ro_ridx = j_c[IDX_W-1:0];
      lsp_pkg::ST_RO_B:  ro_ridx = m_c[IDX_W-1:0];
      lsp_pkg::ST_SW_A:  ram_raddr = a_at(j_c, k_c);
      lsp_pkg::ST_SW_B:  ram_raddr = a_at(m_c, k_c);
      lsp_pkg::ST_SW_C: begin
        ram_we    = 1'b1;
        ram_waddr = a_at(j_c, k_c);
      end
      lsp_pkg::ST_SW_D: begin
        ram_we    = 1'b1;
        ram_waddr = a_at(m_c, k_c);
        ram_wdata = tmp;
      end
      lsp_pkg::ST_EL_B: ram_raddr = a_at(i_c, j_c);
      lsp_pkg::ST_EL_C: div_start = 1'b1;
      lsp_pkg::ST_EL_K: ram_raddr = a_at(j_c, k_c);
      lsp_pkg::ST_EL_K2: begin
        ram_raddr = a_at(i_c, k_c);
        mul_start = 1'b1;
      end
      lsp_pkg::ST_EL_K4: begin
        ram_we    = 1'b1;
        ram_wdata = lsp_pkg::sat32(64'(el_d));
      end
      lsp_pkg::ST_EL_WF: begin
        ram_we    = 1'b1;
        ram_waddr = a_at(i_c, j_c);
        ram_wdata = f;
      end
      lsp_pkg::ST_FW_J, lsp_pkg::ST_BK_J: ram_raddr = a_at(i_c, j_c);
      lsp_pkg::ST_FW_J2, lsp_pkg::ST_BK_J2: begin
        mul_start = 1'b1;
        mul_a     = ram_rdata;
        mul_b     = sol_rd;
        sol_ridx  = j_c[IDX_W-1:0];
      end
      lsp_pkg::ST_BK_D: begin
        ram_raddr = a_at(i_c, i_c);
        sol_ridx  = i_c[IDX_W-1:0];
      end
      lsp_pkg::ST_BK_D2: begin
        div_start = 1'b1;
        div_a     = diff;
        div_d     = ram_rdata;
      end
      default: ;
    endcase
  end

  always_comb begin
    unknown_index = lsp_pkg::IDX_PORT_W'(o_c);
    unknown_value = sol_rd;
    is_last       = (o_c + CNT_W'(1) == n_r);
    if (sing_flag) begin
      solve_status = lsp_pkg::STATUS_SING;
    end else if (sat_flag) begin
      solve_status = lsp_pkg::STATUS_SAT;
    end else begin
      solve_status = lsp_pkg::STATUS_OK;
    end
  end

  // control registers and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= lsp_pkg::ST_IDLE;
      size_in_use <= lsp_pkg::SIZE_RESET;
      n_r         <= '0;
      i_c         <= '0;
      j_c         <= '0;
      k_c         <= '0;
      m_c         <= '0;
      o_c         <= '0;
      sat_flag    <= 1'b0;
      sing_flag   <= 1'b0;
      for (int x = 0; x < MAX_N; x++) begin
        row_order[x] <= IDX_W'(x);
        sol[x]       <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_wr && paddr[2:2] == lsp_pkg::CFG_SIZE_IDX) begin
        size_in_use <= pwdata[lsp_pkg::SIZE_W-1:0];
      end
      case (state)
        lsp_pkg::ST_IDLE: begin
          if (in_xfer && req_type == lsp_pkg::REQ_SOLVE) begin
            n_r       <= n_new;
            i_c       <= '0;
            j_c       <= '0;
            sat_flag  <= 1'b0;
            sing_flag <= 1'b0;
            for (int x = 0; x < MAX_N; x++) begin
              row_order[x] <= IDX_W'(x);
            end
          end
        end
        lsp_pkg::ST_PIV_B: begin
          m_c <= j_c;
          i_c <= j_c + CNT_W'(1);
        end
        lsp_pkg::ST_PIV_D: begin
          // strict compare keeps the first row on ties
          if (lsp_pkg::mag32(ram_rdata) > best) begin
            m_c <= i_c;
          end
          i_c <= i_c + CNT_W'(1);
        end
        lsp_pkg::ST_RO_B: begin
          if (m_c != j_c) begin
            row_order[j_c[IDX_W-1:0]] <= ro_rd;
            row_order[m_c[IDX_W-1:0]] <= ro_tmp;
          end
          k_c <= '0;
          i_c <= j_c + CNT_W'(1);
        end
        lsp_pkg::ST_SW_D: k_c <= k_c + CNT_W'(1);
        lsp_pkg::ST_EL_DIV: begin
          if (div_st.done) begin
            k_c <= j_c + CNT_W'(1);
            if (div_st.zero) sing_flag <= 1'b1;
            if (div_st.sat) sat_flag <= 1'b1;
          end
        end
        lsp_pkg::ST_EL_K3: begin
          if (mul_sat) sat_flag <= 1'b1;
        end
        lsp_pkg::ST_EL_K4: begin
          k_c <= k_c + CNT_W'(1);
          if (lsp_pkg::sat_hit(64'(el_d))) sat_flag <= 1'b1;
        end
        lsp_pkg::ST_EL_WF: begin
          if (i_c + CNT_W'(1) != n_r) begin
            i_c <= i_c + CNT_W'(1);
          end else if (j_c + CNT_W'(2) == n_r) begin
            i_c <= '0;
            j_c <= '0;
          end else begin
            j_c <= j_c + CNT_W'(1);
          end
        end
        lsp_pkg::ST_FW_J3, lsp_pkg::ST_BK_J3: begin
          j_c <= j_c + CNT_W'(1);
          if (mul_sat) sat_flag <= 1'b1;
        end
        lsp_pkg::ST_FW_W: begin
          sol[i_c[IDX_W-1:0]] <= lsp_pkg::sat32(64'(fw_d));
          if (lsp_pkg::sat_hit(64'(fw_d))) sat_flag <= 1'b1;
          if (i_c + CNT_W'(1) == n_r) begin
            j_c <= n_r;
          end else begin
            i_c <= i_c + CNT_W'(1);
            j_c <= '0;
          end
        end
        lsp_pkg::ST_BK_D: begin
          if (lsp_pkg::sat_hit(64'(bk_d))) sat_flag <= 1'b1;
        end
        lsp_pkg::ST_BK_DIV: begin
          if (div_st.done) begin
            sol[i_c[IDX_W-1:0]] <= div_q;
            if (div_st.zero) sing_flag <= 1'b1;
            if (div_st.sat) sat_flag <= 1'b1;
            if (i_c == '0) begin
              o_c <= '0;
            end else begin
              i_c <= i_c - CNT_W'(1);
              j_c <= i_c;
            end
          end
        end
        lsp_pkg::ST_OUT: begin
          if (out_xfer) o_c <= o_c + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  // data registers
  always_ff @(posedge clk) begin
    if (state == lsp_pkg::ST_IDLE && in_xfer && req_type == lsp_pkg::REQ_LOAD_B &&
        int'(row_index) < MAX_N) begin
      rhs_store[IDX_W'(row_index)] <= element_value;
    end
    case (state)
      lsp_pkg::ST_IDLE: s <= '0;
      lsp_pkg::ST_PIV_B: best <= lsp_pkg::mag32(ram_rdata);
      lsp_pkg::ST_PIV_D: begin
        if (lsp_pkg::mag32(ram_rdata) > best) best <= lsp_pkg::mag32(ram_rdata);
      end
      lsp_pkg::ST_RO_A: ro_tmp <= ro_rd;
      lsp_pkg::ST_SW_B, lsp_pkg::ST_EL_B: tmp <= ram_rdata;
      lsp_pkg::ST_EL_DIV: begin
        if (div_st.done) f <= div_q;
      end
      lsp_pkg::ST_EL_K3: begin
        mres <= mul_res;
        tmp  <= ram_rdata;
      end
      lsp_pkg::ST_FW_J3, lsp_pkg::ST_BK_J3: s <= s + SUM_W'(mul_res);
      lsp_pkg::ST_FW_W: s <= '0;
      lsp_pkg::ST_BK_D: diff <= lsp_pkg::sat32(64'(bk_d));
      lsp_pkg::ST_BK_DIV: begin
        if (div_st.done) s <= '0;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/lsp_checker.sv =====
// port-level checks of the lu solver and their binding
`timescale 1ns / 1ps
`include "lu_solve_partial_pivot_defines.svh"
module lsp_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [lsp_pkg::IDX_PORT_W-1:0]     unknown_index,
  input logic signed [lsp_pkg::VAL_W-1:0]   unknown_value,
  input logic [lsp_pkg::STATUS_W-1:0]       solve_status,
  input logic                               is_last
);

  // a stalled result holds
  `LSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(unknown_value) && $stable(unknown_index))
  // no input is taken while results are pending
  `LSP_ASSERT_SAME(a_busy_out, out_valid, in_stall)
  // the last transfer ends the run
  `LSP_ASSERT_NEXT(a_last_end, out_valid && !out_stall && is_last, !out_valid)
  // a run's results follow each other in index order
  `LSP_ASSERT_NEXT(a_index_step, out_valid && !out_stall && !is_last, out_valid && unknown_index == $past(unknown_index) + 3'd1 && $stable(solve_status))

endmodule

bind lu_solve_partial_pivot lsp_checker u_lsp_checker (.*);

// ===== tb/tb_lu_solve_partial_pivot.sv =====
// self-checking testbench for the lu solver with partial pivoting
`timescale 1ns / 1ps

typedef logic signed [31:0] fx_t;

typedef struct {
  logic [2:0] idx;
  fx_t        val;
  logic [1:0] status;
  logic       last;
} unknown_t;

class lu_scoreboard;
  fx_t        mat[8][8];
  fx_t        rhs[8];
  fx_t        sol[8];
  int         order[8];
  logic [3:0] size_reg;
  bit         sat_seen, sing_seen;
  unknown_t   expected_q[$];
  int         errors;

  function new();
    foreach (mat[i, j]) mat[i][j] = 0;
    foreach (rhs[i]) begin
      rhs[i] = 0;
      sol[i] = 0;
      order[i] = i;
    end
    size_reg = lsp_pkg::SIZE_RESET;
    errors = 0;
  endfunction

  function fx_t clip(longint v);
    if (v > 64'sd2147483647) begin
      sat_seen = 1;
      return lsp_pkg::VAL_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat_seen = 1;
      return lsp_pkg::VAL_MIN;
    end
    return fx_t'(v);
  endfunction

  // product rounded to nearest, ties away from zero
  function fx_t qmul(fx_t a, fx_t b);
    longint     p;
    logic [63:0] m, r;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? -p : p;
    r = (m + 64'd32768) >> 16;
    return clip(p < 0 ? -longint'(r) : longint'(r));
  endfunction

  function fx_t qdiv(fx_t a, fx_t d);
    longint ma, md, q;
    if (d == 0) begin
      sing_seen = 1;
      if (a == 0) return 0;
      return a > 0 ? lsp_pkg::VAL_MAX : lsp_pkg::VAL_MIN;
    end
    ma = (a < 0) ? -longint'(a) : longint'(a);
    md = (d < 0) ? -longint'(d) : longint'(d);
    q = ((ma << 16) + md / 2) / md;
    return clip(((a < 0) != (d < 0)) ? -q : q);
  endfunction

  function void factor_and_solve(int n);
    int     m, t;
    fx_t    tv, f;
    longint s;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int j = 0; j < n - 1; j++) begin
      m = j;
      for (int i = j + 1; i < n; i++)
        if ((mat[i][j] < 0 ? -longint'(mat[i][j]) : longint'(mat[i][j])) >
            (mat[m][j] < 0 ? -longint'(mat[m][j]) : longint'(mat[m][j]))) m = i;
      for (int k = 0; k < n; k++) begin
        tv = mat[j][k];
        mat[j][k] = mat[m][k];
        mat[m][k] = tv;
      end
      t = order[j];
      order[j] = order[m];
      order[m] = t;
      for (int i = j + 1; i < n; i++) begin
        f = qdiv(mat[i][j], mat[j][j]);
        for (int k = j + 1; k < n; k++)
          mat[i][k] = clip(longint'(mat[i][k]) - qmul(f, mat[j][k]));
        mat[i][j] = f;
      end
    end
    for (int i = 0; i < n; i++) begin
      s = 0;
      for (int j = 0; j < i; j++) s += qmul(mat[i][j], sol[j]);
      sol[i] = clip(longint'(rhs[order[i]]) - s);
    end
    for (int i = n - 1; i >= 0; i--) begin
      s = 0;
      for (int j = i + 1; j < n; j++) s += qmul(mat[i][j], sol[j]);
      sol[i] = qdiv(clip(longint'(sol[i]) - s), mat[i][i]);
    end
  endfunction

  function void note_input(logic [1:0] req, logic [2:0] row, logic [2:0] col, fx_t v);
    int       n;
    unknown_t u;
    if (req == lsp_pkg::REQ_LOAD_A) mat[row][col] = v;
    else if (req == lsp_pkg::REQ_LOAD_B) rhs[row] = v;
    else if (req == lsp_pkg::REQ_SOLVE) begin
      n = (size_reg == 0) ? 1 : (size_reg > 8 ? 8 : size_reg);
      sat_seen = 0;
      sing_seen = 0;
      factor_and_solve(n);
      for (int i = 0; i < n; i++) begin
        u.idx = 3'(i);
        u.val = sol[i];
        u.status = sing_seen ? lsp_pkg::STATUS_SING :
                   (sat_seen ? lsp_pkg::STATUS_SAT : lsp_pkg::STATUS_OK);
        u.last = (i == n - 1);
        expected_q.push_back(u);
      end
    end
  endfunction

  function void check(unknown_t got);
    unknown_t exp_u;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result idx %0d val %h", got.idx, got.val);
      return;
    end
    exp_u = expected_q.pop_front();
    if (got.idx !== exp_u.idx || got.val !== exp_u.val || got.status !== exp_u.status ||
        got.last !== exp_u.last) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp idx %0d val %h st %0d last %0d, %s",
                 exp_u.idx, exp_u.val, exp_u.status, exp_u.last,
                 $sformatf("got idx %0d val %h st %0d last %0d",
                           got.idx, got.val, got.status, got.last));
    end
  endfunction
endclass

module tb_lu_solve_partial_pivot;

  localparam logic [lsp_pkg::REQ_W-1:0]   REQ_NONE     = 2'd3;
  localparam logic [lsp_pkg::PADDR_W-1:0] ADDR_SIZE    = 3'd0;
  localparam logic [lsp_pkg::PADDR_W-1:0] ADDR_UNUSED  = 3'd4;
  localparam int                          CYCLE_LIMIT  = 1000000;
  localparam int                          SETTLE       = 20;
  localparam int                          ITEM_TARGET  = 200;
  localparam fx_t                         ONE          = 32'sh00010000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [lsp_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_stall;
  logic [lsp_pkg::REQ_W-1:0] req_type;
  logic [2:0] row_index, col_index;
  logic signed [31:0] element_value;
  logic out_valid, out_stall;
  logic [2:0] unknown_index;
  logic signed [31:0] unknown_value;
  logic [1:0] solve_status;
  logic is_last;

  lu_solve_partial_pivot dut (.*);

  lu_scoreboard sb;
  bit  a_loaded[8][8];
  bit  b_loaded[8];
  int  burst_left, items_sent, cycles, stall_mode;
  int  size_now;

  always #5 clk = ~clk;

  // receiver side: check transfers and stall on a shifting pattern
  always @(posedge clk) begin
    unknown_t got;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        got.idx = unknown_index;
        got.val = unknown_value;
        got.status = solve_status;
        got.last = is_last;
        sb.check(got);
      end
      if (cycles % 50 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= cycles[0];
      endcase
    end
  end

  task automatic apb_write(logic [lsp_pkg::PADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (addr == ADDR_SIZE) begin
      sb.size_reg = data[3:0];
      size_now = (data[3:0] == 0) ? 1 : (data[3:0] > 8 ? 8 : data[3:0]);
    end
  endtask

  task automatic send(logic [1:0] req, int row, int col, fx_t v);
    logic [2:0] r3;
    logic [2:0] c3;
    r3 = 3'(row);
    c3 = 3'(col);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    req_type <= req;
    row_index <= r3;
    col_index <= c3;
    element_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(req, r3, c3, v);
    burst_left--;
    if (req != REQ_NONE) items_sent++;
    if (req == lsp_pkg::REQ_LOAD_A) a_loaded[r3][c3] = 1;
    if (req == lsp_pkg::REQ_LOAD_B) b_loaded[r3] = 1;
  endtask

  // hold off until every expected result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic fx_t rand_val(bit diag);
    case ($urandom_range(0, 9))
      0: return fx_t'($urandom());
      1: case ($urandom_range(0, 4))
           0: return lsp_pkg::VAL_MAX;
           1: return lsp_pkg::VAL_MIN;
           2: return 0;
           3: return 1;
           default: return -1;
         endcase
      2: return 0;
      default: return fx_t'($urandom_range(0, 524288)) - 262144 + (diag ? 8 * ONE : 0);
    endcase
  endfunction

  task automatic load_missing(int n);
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        if (!a_loaded[i][j]) send(lsp_pkg::REQ_LOAD_A, i, j, rand_val(i == j));
    for (int i = 0; i < n; i++)
      if (!b_loaded[i]) send(lsp_pkg::REQ_LOAD_B, i, 0, rand_val(0));
  endtask

  task automatic load_system(int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if ($urandom_range(0, 7) == 0) send(REQ_NONE, $urandom(), $urandom(), $urandom());
        send(lsp_pkg::REQ_LOAD_A, i, j, rand_val(i == j));
      end
      send(lsp_pkg::REQ_LOAD_B, i, $urandom(), rand_val(0));
    end
  endtask

  initial begin
    int kind, code, reps;
    sb = new();
    clk = 0;
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    req_type = lsp_pkg::REQ_LOAD_A;
    row_index = '0;
    col_index = '0;
    element_value = '0;
    out_stall = 0;
    burst_left = 0;
    items_sent = 0;
    cycles = 0;
    stall_mode = 0;
    size_now = 8;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: 2x2 systems
    apb_write(ADDR_SIZE, 32'd2);
    // zero matrix gives a zero pivot
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++) send(lsp_pkg::REQ_LOAD_A, i, j, 0);
    send(lsp_pkg::REQ_LOAD_B, 0, 0, ONE);
    send(lsp_pkg::REQ_LOAD_B, 1, 7, 0);
    send(lsp_pkg::REQ_SOLVE, 0, 0, 0);
    // larger second row forces a row swap
    send(lsp_pkg::REQ_LOAD_A, 0, 0, ONE);
    send(lsp_pkg::REQ_LOAD_A, 0, 1, 2 * ONE);
    send(lsp_pkg::REQ_LOAD_A, 1, 0, 3 * ONE);
    send(lsp_pkg::REQ_LOAD_A, 1, 1, 4 * ONE);
    send(lsp_pkg::REQ_LOAD_B, 0, 0, 5 * ONE);
    send(lsp_pkg::REQ_LOAD_B, 1, 0, -6 * ONE);
    send(lsp_pkg::REQ_SOLVE, 7, 7, '1);
    // refactor the in-place factors without reloading
    send(lsp_pkg::REQ_SOLVE, 0, 0, 0);
    // extreme values drive saturation
    send(lsp_pkg::REQ_LOAD_A, 0, 0, lsp_pkg::VAL_MIN);
    send(lsp_pkg::REQ_LOAD_A, 0, 1, lsp_pkg::VAL_MAX);
    send(lsp_pkg::REQ_LOAD_A, 1, 0, 1);
    send(lsp_pkg::REQ_LOAD_A, 1, 1, -1);
    send(lsp_pkg::REQ_LOAD_B, 0, 0, lsp_pkg::VAL_MAX);
    send(lsp_pkg::REQ_LOAD_B, 1, 0, lsp_pkg::VAL_MIN);
    send(REQ_NONE, 7, 7, lsp_pkg::VAL_MAX);
    send(lsp_pkg::REQ_LOAD_A, 7, 7, lsp_pkg::VAL_MAX);
    send(lsp_pkg::REQ_SOLVE, 0, 0, 0);
    drain();
    apb_write(ADDR_UNUSED, 32'd5);

    // random phases with assorted sizes
    while (items_sent < ITEM_TARGET) begin
      drain();
      code = $urandom_range(0, 9);
      case (code)
        0: apb_write(ADDR_SIZE, 32'd0);
        1: apb_write(ADDR_SIZE, 32'd1);
        6: apb_write(ADDR_SIZE, 32'd8);
        7: apb_write(ADDR_SIZE, 32'd15);
        default: apb_write(ADDR_SIZE, $urandom_range(2, 4));
      endcase
      reps = $urandom_range(1, 3);
      for (int r = 0; r < reps && items_sent < ITEM_TARGET; r++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) load_system(size_now);
        else if (kind == 7)
          for (int i = 0; i < size_now; i++) send(lsp_pkg::REQ_LOAD_B, i, 0, rand_val(0));
        else if (kind == 9)
          repeat ($urandom_range(1, 6))
            send(lsp_pkg::REQ_W'($urandom_range(0, 1)), $urandom(), $urandom(),
                 rand_val(0));
        load_missing(size_now);
        send(lsp_pkg::REQ_SOLVE, $urandom(), $urandom(), $urandom());
      end
    end
    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
